[hw/rtl/accumulator_alu_with_flags_top_macros.svh]
// Assertion macros shared by the accumulator ALU RTL.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_TOP_MACROS_SVH

`ifndef SYNTH

// Clocked property check, disabled while reset is asserted.
`define ACCALU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication check, disabled while reset is asserted.
`define ACCALU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ACCALU_ASSERT(lbl, clk, rstn, prop, msg)
`define ACCALU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/accalu_pkg.sv]
// Types and constants shared by the accumulator ALU modules.
`default_nettype none

package accalu_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_ADC    = 4'd1,
        OP_INC8   = 4'd2,
        OP_DEC8   = 4'd3,
        OP_RLCA   = 4'd4,
        OP_RRCA   = 4'd5,
        OP_RLA    = 4'd6,
        OP_RRA    = 4'd7,
        OP_DAA    = 4'd8,
        OP_CPL    = 4'd9,
        OP_ADD16  = 4'd10,
        OP_INC16  = 4'd11,
        OP_DEC16  = 4'd12,
        OP_LOAD_A = 4'd13
    } op_t;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_ADJ_HI    = 8'h60;
    localparam logic [7:0] DAA_ADJ_LO    = 8'h06;
    localparam logic [7:0] DAA_LIMIT     = 8'h99;
    localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;

    // Flag register, Z in the top bit down to C in the lowest.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    // One input item as held in the input register.
    typedef struct packed {
        op_t         action;
        logic [15:0] word_second;
        logic [15:0] word_first;
        logic [7:0]  operand_byte;
    } alu_item_t;

    // One result item, packed so that result_byte lands in the lowest bits.
    typedef struct packed {
        flags_t      flags;
        logic [7:0]  accumulator_out;
        logic [15:0] result_word;
        logic [7:0]  result_byte;
    } alu_result_t;

    // Handshake between the pipeline stages.
    typedef struct packed {
        logic item_valid;
        logic advance;
    } pipe_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/accalu_in_stage.sv]
// Input register stage of the accumulator ALU.
`default_nettype none

module accalu_in_stage
    import accalu_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire alu_item_t s_item,
    input  wire logic      advance,
    output logic           item_valid,
    output alu_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    alu_item_t item_reg;

    // A new transaction is taken when the register is empty or being drained.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[hw/rtl/accalu_core.sv]
// Accumulator and flag state with the single-pass ALU datapath.
`default_nettype none

module accalu_core
    import accalu_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire alu_item_t item,
    input  wire logic      commit,
    output alu_result_t    result
);

    logic [7:0]  acc_reg;
    logic [7:0]  acc_next;
    flags_t      flags_reg;
    flags_t      flags_next;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [7:0]  inc_dec;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic        daa_hi;
    logic        daa_lo;
    logic [7:0]  daa_adj;
    logic [7:0]  byte_res;
    logic        byte_from_acc;
    logic [15:0] word_res;

    assign a = acc_reg;
    assign b = item.operand_byte;

    // Shared adders for the byte and word additions.
    always_comb begin
        cin   = (item.action == OP_ADC) ? flags_reg.c : 1'b0;
        sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        sum17 = {1'b0, item.word_first} + {1'b0, item.word_second};
        sum13 = {1'b0, item.word_first[11:0]} + {1'b0, item.word_second[11:0]};
    end

    // Decimal adjust decisions use the accumulator and flags before the op.
    always_comb begin
        if (!flags_reg.n) begin
            daa_hi = flags_reg.c || (a > DAA_LIMIT);
            daa_lo = flags_reg.h || (a[3:0] > BCD_DIGIT_MAX);
        end else begin
            daa_hi = flags_reg.c;
            daa_lo = flags_reg.h;
        end
        daa_adj = (daa_hi ? DAA_ADJ_HI : 8'h00) | (daa_lo ? DAA_ADJ_LO : 8'h00);
    end

    // Operation select: next accumulator, flags, byte result and word result.
    always_comb begin
        acc_next      = acc_reg;
        flags_next    = flags_reg;
        inc_dec       = b;
        byte_from_acc = 1'b1;
        word_res      = 16'd0;
        case (item.action)
            OP_ADD, OP_ADC: begin
                acc_next     = sum9[7:0];
                flags_next.z = (sum9[7:0] == 8'd0);
                flags_next.n = 1'b0;
                flags_next.h = nib5[4];
                flags_next.c = sum9[8];
            end
            OP_INC8: begin
                inc_dec       = b + 8'd1;
                byte_from_acc = 1'b0;
                flags_next.h  = (b[3:0] == 4'hF);
                flags_next.z  = (inc_dec == 8'd0);
                flags_next.n  = 1'b0;
            end
            OP_DEC8: begin
                inc_dec       = b - 8'd1;
                byte_from_acc = 1'b0;
                flags_next.h  = (b[3:0] == 4'h0);
                flags_next.z  = (inc_dec == 8'd0);
                flags_next.n  = 1'b1;
            end
            OP_RLCA: begin
                acc_next   = {a[6:0], a[7]};
                flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RRCA: begin
                acc_next   = {a[0], a[7:1]};
                flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_RLA: begin
                acc_next   = {a[6:0], flags_reg.c};
                flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RRA: begin
                acc_next   = {flags_reg.c, a[7:1]};
                flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_DAA: begin
                if (!flags_reg.n) begin
                    acc_next     = a + daa_adj;
                    flags_next.c = daa_hi;
                end else begin
                    acc_next     = a - daa_adj;
                end
                flags_next.h = 1'b0;
                flags_next.z = (acc_next == 8'd0);
            end
            OP_CPL: begin
                acc_next     = ~a;
                flags_next.n = 1'b1;
                flags_next.h = 1'b1;
            end
            OP_ADD16: begin
                word_res     = sum17[15:0];
                flags_next.n = 1'b0;
                flags_next.h = sum13[12];
                flags_next.c = sum17[16];
            end
            OP_INC16: begin
                word_res = item.word_first + 16'd1;
            end
            OP_DEC16: begin
                word_res = item.word_first - 16'd1;
            end
            OP_LOAD_A: begin
                acc_next = b;
            end
            default: begin
                // Unused codes leave the state untouched.
                acc_next = acc_reg;
            end
        endcase
        byte_res = byte_from_acc ? acc_next : inc_dec;
    end

    // Architectural state advances only when the item moves to the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= 8'd0;
            flags_reg <= '0;
        end else if (commit) begin
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
        end
    end

    assign result = '{
        flags:           flags_next,
        accumulator_out: acc_next,
        result_word:     word_res,
        result_byte:     byte_res
    };

endmodule

`default_nettype wire

[hw/rtl/accalu_out_stage.sv]
// Result register stage of the accumulator ALU.
`default_nettype none

module accalu_out_stage
    import accalu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        item_valid,
    input  wire alu_result_t result,
    output logic             advance,
    output logic             m_valid,
    input  wire logic        m_ready,
    output alu_result_t      m_result
);

    logic        valid_reg;
    logic        valid_next;
    alu_result_t result_reg;

    // The pending item moves on when the result register is free or being taken.
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

[hw/rtl/accumulator_alu_with_flags_top.sv]
// Each item passes the input register, the combinational core and the result register in that order.
// Throughput: one transaction per cycle while the output is not blocked, set by the input and result registers.
// The accumulator and flags update in the cycle the item enters the result register.
// The input register can take one more transaction while a finished result waits.
// Reset (synchronous, active low) clears the accumulator, all flags and both valids.
`default_nettype none
`include "accumulator_alu_with_flags_top_macros.svh"

module accumulator_alu_with_flags_top
    import accalu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: operand_byte [7:0], word_first [23:8], word_second [39:24]
    input  wire logic [39:0] s_axis_tdata,
    // tuser: action [3:0]
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: result_byte [7:0], result_word [23:8], accumulator_out [31:24],
    // zero_flag [32], subtract_flag [33], half_carry_flag [34], carry_flag [35],
    // zeros [39:36]
    output logic [39:0]      m_axis_tdata
);

    alu_item_t   s_item;
    alu_item_t   item;
    alu_result_t result;
    alu_result_t m_result;
    logic        item_valid;
    logic        advance;

    // Unpack the incoming transaction.
    assign s_item = '{
        action:       op_t'(s_axis_tuser),
        word_second:  s_axis_tdata[39:24],
        word_first:   s_axis_tdata[23:8],
        operand_byte: s_axis_tdata[7:0]
    };

    accalu_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    accalu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .commit  (advance),
        .result  (result)
    );

    accalu_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (m_result)
    );

    // Pack the result transaction, Z in the lowest flag bit up to C.
    assign m_axis_tdata = {4'd0, m_result.flags.c, m_result.flags.h, m_result.flags.n,
                           m_result.flags.z, m_result.accumulator_out, m_result.result_word,
                           m_result.result_byte};

    // The input stalls only when both stages hold items and the output is blocked.
    `ACCALU_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_axis_tready,
        item_valid && m_axis_tvalid && !m_axis_tready, "input stalled without cause")
    // An item is moved only when the input stage really holds one.
    `ACCALU_ASSERT_IMP(a_advance_valid, aclk, aresetn, advance, item_valid,
        "advance without a pending item")
    // An item that moves shows up as a valid result in the next cycle.
    `ACCALU_ASSERT(a_advance_result, aclk, aresetn, advance |=> m_axis_tvalid,
        "advanced item did not reach the output")

endmodule

`default_nettype wire
